// File: hw/rtl/lfsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsa_pkg: shared types for the lowest free slot allocator
// Item payloads, the slot count register width and the command and status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package lfsa_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CFG_W      = 7;
  localparam int unsigned SLOT_IDX_W = 6;

  localparam logic [CFG_W-1:0] SLOTS_RESET = 7'd64;

  typedef struct packed {
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] departure_time;
  } req_t;

  typedef struct packed {
    logic                  granted;
    logic [SLOT_IDX_W-1:0] slot_index;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;  // write a cleared entry at the sweep address, advance
    logic load;    // capture a new item, restart the search
    logic rd;      // read the entry at the sweep address, advance
    logic emit;    // result regs are valid this cycle
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic addr_last;  // sweep address is on the last slot
  } dp_status_t;

endpackage

// File: hw/rtl/lfsa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsa_dp: slot table and search datapath
// Holds the slot table memory (busy flag plus release time per slot), sweeps
// it one entry per cycle, frees expired slots and claims the lowest free one.
// ----------------------------------------------------------------------------
module lfsa_dp import lfsa_pkg::*; #(
  parameter int unsigned MAX_SLOTS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        cmd_i,
  output dp_status_t       status_o,
  input  req_t             req_i,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output res_t             res_o
);

  localparam int unsigned IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CMP_W = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SLOTS - 1);

  typedef struct packed {
    logic              busy;
    logic [TIME_W-1:0] release_time;
  } slot_entry_t;

  slot_entry_t slot_mem [MAX_SLOTS];

  logic [CFG_W-1:0]  slots_q;
  logic [IDX_W-1:0]  addr_q, addr_d;
  logic              pend_q;
  logic [IDX_W-1:0]  pend_idx_q;
  slot_entry_t       rd_data_q;
  req_t              req_q;
  logic              found_q, found_d;
  logic [IDX_W-1:0]  found_idx_q, found_idx_d;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  slot_entry_t       wr_data;
  logic              expired;
  logic              usable;

  // slot count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= SLOTS_RESET;
    end else if (cfg_we_i) begin
      slots_q <= cfg_wdata_i;
    end
  end

  // sweep address, wraps after the last slot
  always_comb begin
    addr_d = addr_q;
    if (cmd_i.load) begin
      addr_d = '0;
    end else if (cmd_i.clr_wr || cmd_i.rd) begin
      addr_d = (addr_q == LAST_IDX) ? '0 : addr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      pend_q <= 1'b0;
    end else begin
      addr_q <= addr_d;
      pend_q <= cmd_i.rd;
    end
  end

  assign status_o.addr_last = (addr_q == LAST_IDX);

  // capture the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  // read port: one entry per cycle, registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_data_q  <= slot_mem[addr_q];
      pend_idx_q <= addr_q;
    end
  end

  // clear the entry at the sweep address on clr_wr, free an expired entry, claim the first usable free one
  always_comb begin
    expired = rd_data_q.busy && (rd_data_q.release_time <= req_q.arrival_time);
    usable  = !(rd_data_q.busy && !expired) && !found_q &&
              (CMP_W'(pend_idx_q) < CMP_W'(slots_q));

    found_d     = found_q;
    found_idx_d = found_idx_q;
    wr_en       = 1'b0;
    wr_addr     = pend_idx_q;
    wr_data     = rd_data_q;

    priority if (cmd_i.clr_wr) begin
      wr_en        = 1'b1;
      wr_addr      = addr_q;
      wr_data.busy = 1'b0;
    end else if (cmd_i.load) begin
      found_d     = 1'b0;
      found_idx_d = '0;
    end else if (pend_q && usable) begin
      wr_en                = 1'b1;
      wr_data.busy         = 1'b1;
      wr_data.release_time = req_q.departure_time;
      found_d              = 1'b1;
      found_idx_d          = pend_idx_q;
    end else if (pend_q && expired) begin
      wr_en        = 1'b1;
      wr_data.busy = 1'b0;
    end else begin
      // hold the table
      wr_en = 1'b0;
    end
  end

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      found_idx_q <= '0;
    end else begin
      found_q     <= found_d;
      found_idx_q <= found_idx_d;
    end
  end

  // result, meaningful while the controller emits
  assign res_o.granted    = found_q;
  assign res_o.slot_index = found_q ? SLOT_IDX_W'(found_idx_q) : '0;

  // a grant never moves once made for the current item
  a_found_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q && !cmd_i.load |=> found_q && $stable(found_idx_q))
    else $error("granted slot changed within an item");

  // a slot at or above the configured count is never claimed
  a_grant_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(found_q) |-> (CMP_W'(found_idx_q) < CMP_W'(slots_q)))
    else $error("granted slot outside the configured count");

endmodule

// File: hw/rtl/lfsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsa_ctrl: sequencing state machine
// Runs the table clearing pass after reset, then per item one sweep over the
// slot table, a drain state for the last read and a one-cycle result.
// ----------------------------------------------------------------------------
module lfsa_ctrl import lfsa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  output logic       res_valid_o,
  output ctrl_cmd_t  cmd_o,
  input  dp_status_t status_i
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SWEEP = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start && !busy;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.addr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd_o.rd = 1'b1;
        if (status_i.addr_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        busy       = 1'b0;
        cmd_o.emit = 1'b1;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SWEEP;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign res_valid_o = cmd_o.emit;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  // an accepted item always starts a sweep
  a_accept_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_SWEEP)
    else $error("accepted item did not start a sweep");

  // every sweep ends in one result, with the drain state between its last read and the result
  a_sweep_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SWEEP && status_i.addr_last |=> ##1 res_valid_o)
    else $error("sweep finished without a result");

endmodule

// File: hw/rtl/lowest_free_slot_allocator.sv
`timescale 1ns / 1ps
// An accepted item is followed by a sweep over the slot table, a drain
// state and the result strobe. No new item is taken during the sweep;
// start is taken again in the result cycle. The pace is set by the sweep,
// which has one read port and visits one slot per cycle.
// Reset: busy stays high for a clearing pass that marks every slot free.
// Results cannot be stalled; each is shown for one cycle.
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator: top level
// Frees slots whose release time has been reached at each request's arrival, then
// grants the lowest free slot below the configured slot count.
// ----------------------------------------------------------------------------
module lowest_free_slot_allocator import lfsa_pkg::*; #(
  parameter int unsigned MAX_SLOTS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  req_t             req_i,
  output logic             res_valid_o,
  output res_t             res_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencing
  lfsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .res_valid_o (res_valid_o),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // slot table and search
  lfsa_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_o       (res_o)
  );

endmodule
